[sv/free_space_map_checker_top_assert.svh]
// assertion macros for the free-space map checker
// all macros sample on clk and are disabled while rst_n is low
`ifndef FREE_SPACE_MAP_CHECKER_TOP_ASSERT_SVH
`define FREE_SPACE_MAP_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define FSMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FSMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/fsmc_pkg.sv]
// ----------------------------------------------------------------------------
// fsmc_pkg
// shared types and constants of the free-space map checker
// ----------------------------------------------------------------------------
`default_nettype none

package fsmc_pkg;

  localparam int unsigned MAX_REGIONS_DEF  = 16;
  localparam int unsigned INFO_BYTES       = 8;
  localparam int unsigned MAX_BITMAP_BYTES = 65535;

  localparam logic [2:0] OP_LOAD    = 3'd0;
  localparam logic [2:0] OP_INFO    = 3'd1;
  localparam logic [2:0] OP_EXTENT  = 3'd2;
  localparam logic [2:0] OP_BMHDR   = 3'd3;
  localparam logic [2:0] OP_BMBYTE  = 3'd4;
  localparam logic [2:0] OP_FINISH  = 3'd5;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_INFO   = 2'd1;
  localparam logic [1:0] KIND_EXTENT = 2'd2;
  localparam logic [1:0] KIND_BITMAP = 2'd3;

  localparam logic CFG_SECTOR_SHIFT = 1'b0;
  localparam logic CFG_REGION_COUNT = 1'b1;

  localparam logic [4:0]  SHIFT_RESET   = 5'd12;
  localparam logic [4:0]  SHIFT_MIN     = 5'd9;
  localparam logic [4:0]  SHIFT_MAX     = 5'd16;
  localparam logic [32:0] RUNS_MAX      = '1;
  localparam logic [7:0]  BYTE_ONES     = 8'hFF;
  localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [4:0] sector_shift;
    logic [4:0] region_count;
  } cfg_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] region_index;
    logic [1:0] kind;
  } result_t;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] span;
  } region_t;

  typedef struct packed {
    logic        info_seen;
    logic        prev_bit;
    logic        bitmap_mode;
    logic [31:0] expected;
    logic [32:0] found;
    logic [63:0] covered;
  } entry_t;

endpackage

`default_nettype wire

[sv/fsmc_ram.sv]
// ----------------------------------------------------------------------------
// fsmc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fsmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[sv/fsmc_core.sv]
// ----------------------------------------------------------------------------
// fsmc_core
// sequencer: region search, entry read-modify-write and finish sweep
// ----------------------------------------------------------------------------
`default_nettype none

module fsmc_core #(
  parameter int unsigned MAX_REGIONS = fsmc_pkg::MAX_REGIONS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_operation,
  input  wire logic [3:0]            in_slot,
  input  wire logic [63:0]           in_start_address,
  input  wire logic [63:0]           in_span_length,
  input  wire logic [31:0]           in_run_total,
  input  wire logic [31:0]           in_info_flags,
  input  wire logic [15:0]           in_payload_size,
  input  wire logic [7:0]            in_bitmap_byte,
  input  wire logic                  in_last_byte,
  input  wire fsmc_pkg::cfg_t        cfg,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output fsmc_pkg::result_t          res
);

  import fsmc_pkg::*;

  localparam int unsigned AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned NW = $clog2(MAX_REGIONS + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PREP     = 4'd1;
  localparam logic [3:0] ST_SRCH_RD  = 4'd2;
  localparam logic [3:0] ST_SRCH_CMP = 4'd3;
  localparam logic [3:0] ST_ENT_RD   = 4'd4;
  localparam logic [3:0] ST_ENT_CHK  = 4'd5;
  localparam logic [3:0] ST_BYTE_RD  = 4'd6;
  localparam logic [3:0] ST_BYTE_UPD = 4'd7;
  localparam logic [3:0] ST_FIN_RD   = 4'd8;
  localparam logic [3:0] ST_FIN_CHK  = 4'd9;
  localparam logic [3:0] ST_RESP     = 4'd10;

  // control state
  logic [3:0]    state_r, state_nxt;
  logic          err_r, err_nxt;
  logic [19:0]   bits_left_r, bits_left_nxt;
  logic [15:0]   bytes_left_r, bytes_left_nxt;
  logic [AW-1:0] open_r, open_nxt;
  logic [AW-1:0] i_r, i_nxt;

  // captured item and per-item working values
  logic [2:0]    op_r;
  logic [3:0]    slot_r;
  logic [63:0]   a_r, len_r;
  logic [31:0]   runs_r, flags_r;
  logic [15:0]   psz_r;
  logic [7:0]    byte_r;
  logic          last_r;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [63:0]   s_r, s_nxt, sp_r, sp_nxt;
  logic          al_ok_r, al_ok_nxt;
  logic          esz_ok_r, esz_ok_nxt;
  logic [19:0]   nbits_r, nbits_nxt;
  logic [63:0]   end_r, end_nxt;
  result_t       res_r, res_nxt;

  // rams
  logic          tbl_we, ent_we;
  logic [AW-1:0] tbl_waddr, ent_waddr, ent_raddr;
  region_t       tbl_wdata, tbl_rdata;
  entry_t        ent_wdata, ent_rdata;

  fsmc_ram #(.WIDTH($bits(region_t)), .DEPTH(MAX_REGIONS), .AW(AW)) u_tbl_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .raddr(i_r),
    .rdata(tbl_rdata)
  );

  fsmc_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_REGIONS), .AW(AW)) u_ent_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(ent_waddr),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  always_comb begin
    ent_raddr = idx_r;
    if (state_r == ST_BYTE_RD || state_r == ST_BYTE_UPD) begin
      ent_raddr = open_r;
    end else if (state_r == ST_FIN_RD || state_r == ST_FIN_CHK) begin
      ent_raddr = i_r;
    end
  end

  // searched slot count
  logic [NW-1:0] n_regions;
  always_comb begin
    if (32'(cfg.region_count) > 32'(MAX_REGIONS)) begin
      n_regions = NW'(MAX_REGIONS);
    end else begin
      n_regions = NW'(cfg.region_count);
    end
  end

  logic i_last;
  assign i_last = (NW'(i_r) + NW'(1)) == n_regions;

  // sector shift, clamped
  logic [4:0]  sh_u;
  logic [63:0] mask;
  logic [63:0] nbits_full;
  logic [63:0] esz;
  always_comb begin
    sh_u = cfg.sector_shift;
    if (cfg.sector_shift < SHIFT_MIN) begin
      sh_u = SHIFT_MIN;
    end else if (cfg.sector_shift > SHIFT_MAX) begin
      sh_u = SHIFT_MAX;
    end
    mask       = (64'd1 << sh_u) - 64'd1;
    nbits_full = len_r >> sh_u;
    esz        = (nbits_full >> 3) + {63'd0, |nbits_full[2:0]};
  end

  // range fit against the slot just read
  logic [63:0] off;
  logic        fit;
  assign off = a_r - tbl_rdata.start;
  assign fit = (off <= tbl_rdata.span) && (len_r <= tbl_rdata.span - off);

  // bitmap byte: valid bits and run starts
  logic [3:0] nvalid;
  logic       final_byte;
  logic       tail_bad;
  logic [3:0] run_cnt;
  logic       pb;
  logic       new_prev;
  logic [33:0] found_sum;
  always_comb begin
    nvalid     = (bits_left_r < 20'(BITS_PER_BYTE)) ? bits_left_r[3:0] : BITS_PER_BYTE;
    final_byte = bytes_left_r == 16'd1;
    tail_bad   = final_byte && (nvalid < BITS_PER_BYTE) &&
                 ((byte_r & 8'(BYTE_ONES << nvalid)) != 8'd0);
    run_cnt = 4'd0;
    for (int k = 0; k < 8; k++) begin
      pb = (k == 0) ? ent_rdata.prev_bit : byte_r[(k == 0) ? 0 : k - 1];
      if ((4'(k) < nvalid) && byte_r[k] && !pb) begin
        run_cnt = run_cnt + 4'd1;
      end
    end
    new_prev  = (nvalid == 4'd0) ? ent_rdata.prev_bit : byte_r[3'(nvalid - 4'd1)];
    found_sum = {1'b0, ent_rdata.found} + 34'(run_cnt);
  end

  always_comb begin
    state_nxt      = state_r;
    err_nxt        = err_r;
    bits_left_nxt  = bits_left_r;
    bytes_left_nxt = bytes_left_r;
    open_nxt       = open_r;
    i_nxt          = i_r;
    idx_nxt        = idx_r;
    s_nxt          = s_r;
    sp_nxt         = sp_r;
    al_ok_nxt      = al_ok_r;
    esz_ok_nxt     = esz_ok_r;
    nbits_nxt      = nbits_r;
    end_nxt        = end_r;
    res_nxt        = res_r;
    tbl_we         = 1'b0;
    tbl_waddr      = AW'(slot_r);
    tbl_wdata      = '{start: a_r, span: len_r};
    ent_we         = 1'b0;
    ent_waddr      = idx_r;
    ent_wdata      = ent_rdata;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end

      ST_PREP: begin
        res_nxt    = '{bad: 1'b1, region_index: 4'd0, kind: KIND_NONE};
        al_ok_nxt  = ((a_r & mask) == 64'd0) && ((len_r & mask) == 64'd0);
        esz_ok_nxt = (esz == 64'(psz_r)) && (esz <= 64'(MAX_BITMAP_BYTES));
        nbits_nxt  = nbits_full[19:0];
        end_nxt    = a_r + len_r;
        i_nxt      = '0;
        state_nxt  = ST_RESP;
        if (err_r || (bytes_left_r != 16'd0 && op_r != OP_BMBYTE)) begin
          res_nxt.bad = 1'b1;
        end else begin
          case (op_r)
            OP_LOAD: begin
              res_nxt.bad = 1'b0;
              if (32'(slot_r) < 32'(MAX_REGIONS)) begin
                tbl_we    = 1'b1;
                ent_we    = 1'b1;
                ent_waddr = AW'(slot_r);
                ent_wdata = '0;
              end
            end
            OP_INFO, OP_EXTENT, OP_BMHDR: begin
              // empty range or one that wraps past the top never matches
              if (len_r != 64'd0 && a_r <= ~len_r && n_regions != '0) begin
                state_nxt = ST_SRCH_RD;
              end
            end
            OP_BMBYTE: begin
              if (bytes_left_r != 16'd0 && last_r == final_byte && !tail_bad) begin
                state_nxt = ST_BYTE_RD;
              end
            end
            OP_FINISH: begin
              if (n_regions == '0) begin
                res_nxt.bad = 1'b0;
              end else begin
                state_nxt = ST_FIN_RD;
              end
            end
            default: res_nxt.bad = 1'b1;
          endcase
        end
      end

      ST_SRCH_RD: state_nxt = ST_SRCH_CMP;

      ST_SRCH_CMP: begin
        // the user must load regions sorted (unenforced): a start above the record ends the search
        if (a_r < tbl_rdata.start) begin
          state_nxt = ST_RESP;
        end else if (fit) begin
          idx_nxt   = i_r;
          s_nxt     = tbl_rdata.start;
          sp_nxt    = tbl_rdata.span;
          state_nxt = ST_ENT_RD;
        end else if (i_last) begin
          state_nxt = ST_RESP;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = ST_SRCH_RD;
        end
      end

      ST_ENT_RD: state_nxt = ST_ENT_CHK;

      ST_ENT_CHK: begin
        state_nxt = ST_RESP;
        case (op_r)
          OP_INFO: begin
            if (psz_r == 16'(INFO_BYTES) && a_r == s_r && len_r == sp_r &&
                !ent_rdata.info_seen && flags_r[31:1] == 31'd0) begin
              ent_we                = 1'b1;
              ent_wdata.expected    = runs_r;
              ent_wdata.bitmap_mode = flags_r[0];
              ent_wdata.covered     = a_r;
              ent_wdata.info_seen   = 1'b1;
              res_nxt = '{bad: 1'b0, region_index: 4'(idx_r), kind: KIND_INFO};
            end
          end
          OP_EXTENT: begin
            if (ent_rdata.info_seen && al_ok_r && a_r >= ent_rdata.covered &&
                psz_r == 16'd0 && !ent_rdata.bitmap_mode) begin
              ent_we            = 1'b1;
              ent_wdata.found   = (ent_rdata.found == RUNS_MAX) ? RUNS_MAX :
                                  ent_rdata.found + 33'd1;
              ent_wdata.covered = end_r;
              res_nxt = '{bad: 1'b0, region_index: 4'(idx_r), kind: KIND_EXTENT};
            end
          end
          default: begin
            // bitmap header opens the record
            if (ent_rdata.info_seen && al_ok_r && a_r == ent_rdata.covered &&
                esz_ok_r && ent_rdata.bitmap_mode) begin
              ent_we            = 1'b1;
              ent_wdata.covered = end_r;
              bits_left_nxt     = nbits_r;
              bytes_left_nxt    = psz_r;
              open_nxt          = idx_r;
              res_nxt = '{bad: 1'b0, region_index: 4'(idx_r), kind: KIND_NONE};
            end
          end
        endcase
      end

      ST_BYTE_RD: state_nxt = ST_BYTE_UPD;

      ST_BYTE_UPD: begin
        ent_we             = 1'b1;
        ent_waddr          = open_r;
        ent_wdata.found    = found_sum[33] ? RUNS_MAX : found_sum[32:0];
        ent_wdata.prev_bit = new_prev;
        bits_left_nxt      = bits_left_r - 20'(nvalid);
        bytes_left_nxt     = bytes_left_r - 16'd1;
        res_nxt            = '{bad: 1'b0, region_index: 4'(open_r), kind: KIND_NONE};
        if (final_byte) begin
          bits_left_nxt = '0;
          res_nxt       = '{bad: 1'b0, region_index: 4'(open_r), kind: KIND_BITMAP};
        end
        state_nxt = ST_RESP;
      end

      ST_FIN_RD: state_nxt = ST_FIN_CHK;

      ST_FIN_CHK: begin
        if (!ent_rdata.info_seen || ent_rdata.found != {1'b0, ent_rdata.expected} ||
            (ent_rdata.bitmap_mode &&
             ent_rdata.covered != tbl_rdata.start + tbl_rdata.span)) begin
          state_nxt = ST_RESP;
        end else if (i_last) begin
          res_nxt.bad = 1'b0;
          state_nxt   = ST_RESP;
        end else begin
          i_nxt     = i_r + AW'(1);
          state_nxt = ST_FIN_RD;
        end
      end

      ST_RESP: begin
        if (res_r.bad) begin
          err_nxt        = 1'b1;
          bits_left_nxt  = '0;
          bytes_left_nxt = '0;
        end
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      err_r        <= 1'b0;
      bits_left_r  <= '0;
      bytes_left_r <= '0;
      open_r       <= '0;
      i_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      err_r        <= err_nxt;
      bits_left_r  <= bits_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      open_r       <= open_nxt;
      i_r          <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r    <= in_operation;
      slot_r  <= in_slot;
      a_r     <= in_start_address;
      len_r   <= in_span_length;
      runs_r  <= in_run_total;
      flags_r <= in_info_flags;
      psz_r   <= in_payload_size;
      byte_r  <= in_bitmap_byte;
      last_r  <= in_last_byte;
    end
    idx_r    <= idx_nxt;
    s_r      <= s_nxt;
    sp_r     <= sp_nxt;
    al_ok_r  <= al_ok_nxt;
    esz_ok_r <= esz_ok_nxt;
    nbits_r  <= nbits_nxt;
    end_r    <= end_nxt;
    res_r    <= res_nxt;
  end

  assign in_stall  = state_r != ST_IDLE;
  assign res_valid = state_r == ST_RESP;
  assign res       = res_r;

endmodule

`default_nettype wire

[sv/free_space_map_checker_top.sv]
// steps: a load goes from prep to resp, a bitmap byte reads and updates its entry,
//   info, extent and bitmap header search the slot table ram in order, then check
//   the entry, and a finish sweeps the slot table ram; one item at a time, the
//   search and sweep take longest, and the result register frees the core
// reset: synchronous active-low; no ram clearing pass, slots are valid once loaded
// ----------------------------------------------------------------------------
// free_space_map_checker_top
// checks free-space records against a loaded table of regions
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_space_map_checker_top_assert.svh"

module free_space_map_checker_top #(
  parameter int unsigned MAX_REGIONS = fsmc_pkg::MAX_REGIONS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_operation,
  input  wire logic [3:0]  in_slot,
  input  wire logic [63:0] in_start_address,
  input  wire logic [63:0] in_span_length,
  input  wire logic [31:0] in_run_total,
  input  wire logic [31:0] in_info_flags,
  input  wire logic [15:0] in_payload_size,
  input  wire logic [7:0]  in_bitmap_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_status,
  output logic [3:0]       out_region_index,
  output logic [1:0]       out_record_kind,
  output logic             out_record_done,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);

  import fsmc_pkg::*;

  logic [4:0] sector_shift_r, region_count_r;
  cfg_t       cfg;
  logic       res_valid, res_ready;
  result_t    res;
  logic       out_valid_r, out_valid_nxt;
  result_t    out_r;

  assign cfg_ready = 1'b1;
  assign cfg       = '{sector_shift: sector_shift_r, region_count: region_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_shift_r <= SHIFT_RESET;
      region_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SECTOR_SHIFT) begin
        sector_shift_r <= cfg_data;
      end
      if (cfg_index == CFG_REGION_COUNT) begin
        region_count_r <= cfg_data;
      end
    end
  end

  fsmc_core #(.MAX_REGIONS(MAX_REGIONS)) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_slot         (in_slot),
    .in_start_address(in_start_address),
    .in_span_length  (in_span_length),
    .in_run_total    (in_run_total),
    .in_info_flags   (in_info_flags),
    .in_payload_size (in_payload_size),
    .in_bitmap_byte  (in_bitmap_byte),
    .in_last_byte    (in_last_byte),
    .cfg             (cfg),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  // result register: free when empty or its transfer completes now
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.bad;
  assign out_region_index = out_r.region_index;
  assign out_record_kind  = out_r.kind;
  assign out_record_done  = out_r.kind != KIND_NONE;

  `FSMC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "core took a second item")
  `FSMC_ASSERT_NEXT(a_error_sticky, out_valid && out_status, !out_valid || out_status, "error not latched")
  `FSMC_ASSERT_NOW(a_error_clean, out_valid && out_status, out_region_index == 4'd0 && !out_record_done, "error result carries a record")

endmodule

`default_nettype wire
